>>> rtl/pfr_pkg.sv
`default_nettype none

package pfr_pkg;

  localparam int CHANNEL_BITS_DEF = 10;
  localparam int NUM_CHAN         = 4;
  localparam int APB_AW           = 5;
  localparam int APB_DW           = 32;

  localparam logic [2:0]  BPP_RESET   = 3'd4;
  localparam logic [31:0] RED_RESET   = 32'h00FF_0000;
  localparam logic [31:0] GREEN_RESET = 32'h0000_FF00;
  localparam logic [31:0] BLUE_RESET  = 32'h0000_00FF;
  localparam logic [31:0] ALPHA_RESET = 32'h0000_0000;

  typedef enum logic [2:0] {
    REG_BPP   = 3'd0,
    REG_RED   = 3'd1,
    REG_GREEN = 3'd2,
    REG_BLUE  = 3'd3,
    REG_ALPHA = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]                 bpp;
    logic [NUM_CHAN-1:0][31:0]  mask;
  } cfg_t;

  // lowest set bit position, 31 for an empty mask
  function automatic logic [4:0] trail_zeros(input logic [31:0] m);
    logic [31:0] low;
    logic [4:0]  n;
    low = m & (~m + 32'd1);
    n   = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (low[i]) begin
        n = n | 5'(i);
      end
    end
    if (m == 32'd0) begin
      n = 5'd31;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pixel_format_to_rgba8888_top.sv
// throughput: one pixel per clock while the output is not stalled, set by a
//   six-stage pipeline per channel (field extract, numerator, four radix-4 divide stages)
// output stalls hold the whole pipeline; input is taken while the output
//   stage is empty or being drained
// rst_ni clears all valid bits and loads the register reset values
`default_nettype none

module pixel_format_to_rgba8888_top
  import pfr_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [31:0]       s_axis_tdata,  // pixel_word
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [31:0]       m_axis_tdata   // red_out, green_out, blue_out, alpha_out
);

  localparam int LAT = 6;

  cfg_t                cfg;
  logic                adv;
  logic [LAT-1:0]      vld_q;
  logic [31:0]         word;
  logic [NUM_CHAN-1:0][7:0] chan;

  pfr_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign adv           = ~vld_q[LAT-1] | m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  always_comb begin
    case (cfg.bpp) inside
      3'd0, 3'd1, 3'd2: word = {16'd0, s_axis_tdata[15:0]};
      3'd3:             word = {8'd0, s_axis_tdata[23:0]};
      default:          word = s_axis_tdata;
    endcase
  end

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    pfr_chan #(
      .CHANNEL_BITS(CHANNEL_BITS)
    ) u_chan (
      .clk_i (clk_i),
      .en_i  (adv),
      .word_i(word),
      .mask_i(cfg.mask[c]),
      .chan_o(chan[c])
    );
  end

  assign m_axis_tdata = {(cfg.mask[3] == 32'd0) ? 8'hFF : chan[3], chan[2], chan[1], chan[0]};

endmodule

`default_nettype wire

>>> rtl/pfr_apb_regs.sv
`default_nettype none

module pfr_apb_regs
  import pfr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_BPP:   cfg_d.bpp     = pwdata[2:0];
        REG_RED:   cfg_d.mask[0] = pwdata;
        REG_GREEN: cfg_d.mask[1] = pwdata;
        REG_BLUE:  cfg_d.mask[2] = pwdata;
        REG_ALPHA: cfg_d.mask[3] = pwdata;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BPP:   prdata = {29'd0, cfg_q.bpp};
      REG_RED:   prdata = cfg_q.mask[0];
      REG_GREEN: prdata = cfg_q.mask[1];
      REG_BLUE:  prdata = cfg_q.mask[2];
      REG_ALPHA: prdata = cfg_q.mask[3];
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bpp     <= BPP_RESET;
      cfg_q.mask[0] <= RED_RESET;
      cfg_q.mask[1] <= GREEN_RESET;
      cfg_q.mask[2] <= BLUE_RESET;
      cfg_q.mask[3] <= ALPHA_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/pfr_div_stage.sv
`default_nettype none

module pfr_div_stage
  import pfr_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int HI_BIT       = 7
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [CHANNEL_BITS+7:0] rem_i,
  input  wire logic [7:0]              quo_i,
  input  wire logic [CHANNEL_BITS-1:0] den_i,
  input  wire logic                    zero_i,
  output logic      [CHANNEL_BITS+7:0] rem_o,
  output logic      [7:0]              quo_o,
  output logic      [CHANNEL_BITS-1:0] den_o,
  output logic                         zero_o
);

  localparam int NW = CHANNEL_BITS + 8;

  logic [NW-1:0]           rem_d, rem_q;
  logic [7:0]              quo_d, quo_q;
  logic [CHANNEL_BITS-1:0] den_q;
  logic                    zero_q;

  // two restoring steps per stage
  always_comb begin
    logic [NW-1:0] trial;
    rem_d = rem_i;
    quo_d = quo_i;
    for (int j = 0; j < 2; j++) begin
      trial = NW'(den_i) << (HI_BIT - j);
      if (rem_d >= trial) begin
        rem_d             = rem_d - trial;
        quo_d[HI_BIT - j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      den_q  <= den_i;
      zero_q <= zero_i;
    end
  end

  assign rem_o  = rem_q;
  assign quo_o  = quo_q;
  assign den_o  = den_q;
  assign zero_o = zero_q;

endmodule

`default_nettype wire

>>> rtl/pfr_chan.sv
`default_nettype none

module pfr_chan
  import pfr_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] word_i,
  input  wire logic [31:0] mask_i,
  output logic      [7:0]  chan_o
);

  localparam int NW = CHANNEL_BITS + 8;

  logic [4:0]              tz;
  logic [31:0]             val_sh, max_sh;
  logic [CHANNEL_BITS-1:0] val_q, max_q;
  logic [NW-1:0]           num_d, num_q;
  logic [CHANNEL_BITS-1:0] den_q;
  logic                    zero_q;

  // extract field
  assign tz     = trail_zeros(mask_i);
  assign val_sh = (word_i & mask_i) >> tz;
  assign max_sh = mask_i >> tz;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_sh[CHANNEL_BITS-1:0];
      max_q <= max_sh[CHANNEL_BITS-1:0];
    end
  end

  // v*255 + max/2
  assign num_d = NW'({val_q, 8'h00}) - NW'(val_q) + NW'(max_q >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      den_q  <= max_q;
      zero_q <= (max_q == '0);
    end
  end

  logic [4:0][NW-1:0]           rem;
  logic [4:0][7:0]              quo;
  logic [4:0][CHANNEL_BITS-1:0] den;
  logic [4:0]                   zero;

  assign rem[0]  = num_q;
  assign quo[0]  = 8'd0;
  assign den[0]  = den_q;
  assign zero[0] = zero_q;

  for (genvar s = 0; s < 4; s++) begin : g_div
    pfr_div_stage #(
      .CHANNEL_BITS(CHANNEL_BITS),
      .HI_BIT      (7 - 2 * s)
    ) u_stage (
      .clk_i (clk_i),
      .en_i  (en_i),
      .rem_i (rem[s]),
      .quo_i (quo[s]),
      .den_i (den[s]),
      .zero_i(zero[s]),
      .rem_o (rem[s+1]),
      .quo_o (quo[s+1]),
      .den_o (den[s+1]),
      .zero_o(zero[s+1])
    );
  end

  assign chan_o = zero[4] ? 8'd0 : quo[4];

endmodule

`default_nettype wire
